[hdl/hbw_pkg.sv]
// Shared types and constants of the task heartbeat watchdog.
package hbw_pkg;

    localparam int TimeW   = 32;
    localparam int PeriodW = 16;
    localparam int DogW    = 12;
    localparam int TaskW   = 4;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 32;

    localparam logic [CfgIdxW-1:0] REG_CHECK_PERIOD = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STALL_WINDOW = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GRACE_PERIOD = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_DOG_RELOAD   = 2'd3;

    localparam logic [PeriodW-1:0] CHECK_PERIOD_RST = 16'd1000;
    localparam logic [TimeW-1:0]   STALL_WINDOW_RST = 32'd3000;
    localparam logic [TimeW-1:0]   GRACE_PERIOD_RST = 32'd20000;
    localparam logic [DogW-1:0]    DOG_RELOAD_RST   = 12'd4000;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BEAT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GRACE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

[hdl/task_heartbeat_watchdog.sv]
// Top level of the task heartbeat watchdog: sequencer, task scan and countdown.
//
// Words on the slave side are either one-millisecond ticks (tuser = 0) or
// heartbeats from task tdata[3:0] (tuser = 1); every word yields one result
// word. A heartbeat or a tick without a check goes from idle to done; a
// tick that runs a check passes the grace state, and after grace also the
// scan state, where one shared subtract/compare unit walks the task
// timestamps one per cycle. s_tready is high only while the sequencer is idle;
// a finished result sits in the output register so the next word can be taken
// while it waits. Configuration is written through wr_en/wr_index/wr_data and
// must only change while the block is idle.
module task_heartbeat_watchdog #(
    parameter int TASKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] task_number, [7:4] zero
    input  logic        s_tuser,   // [0] action
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] fed, [1] stall_found, [2] in_grace,
                                   // [3] expired, [15:4] dog_count
);

    localparam int IdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TASKS - 1);
    localparam logic [hbw_pkg::TaskW:0] TaskLimit = (hbw_pkg::TaskW + 1)'(TASKS);

    // configuration registers
    logic [hbw_pkg::PeriodW-1:0] check_period_reg;
    logic [hbw_pkg::TimeW-1:0]   stall_window_reg;
    logic [hbw_pkg::TimeW-1:0]   grace_period_reg;
    logic [hbw_pkg::DogW-1:0]    dog_reload_reg;

    // block state
    hbw_pkg::state_t state_reg, state_next;
    logic [hbw_pkg::TimeW-1:0]   time_reg, time_next;
    logic [hbw_pkg::PeriodW-1:0] ccount_reg, ccount_next;
    logic [hbw_pkg::DogW-1:0]    dog_reg, dog_next;
    logic                        tripped_reg, tripped_next;
    logic [hbw_pkg::TimeW-1:0]   beat_time [TASKS];
    logic [TASKS-1:0]            seen_reg, seen_next;

    // per-word working registers
    logic            tick_reg, tick_next;
    logic            fed_reg, fed_next;
    logic            stall_reg, stall_next;
    logic            alive_reg, alive_next;
    logic [IdxW-1:0] idx_reg, idx_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    logic                        accept;
    logic                        beat_ok;
    logic                        out_free;
    logic [hbw_pkg::PeriodW-1:0] ccount_inc;
    logic                        check_due;
    logic [hbw_pkg::TimeW-1:0]   age;
    logic                        task_stale;
    logic                        grace_now;
    logic [hbw_pkg::DogW-1:0]    dog_dec;

    assign s_tready = (state_reg == hbw_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign beat_ok  = ({1'b0, s_tdata[hbw_pkg::TaskW-1:0]} < TaskLimit);

    // A zero period compares true on every tick, same as a period of one.
    assign ccount_inc = ccount_reg + 1'b1;
    assign check_due  = (ccount_inc >= check_period_reg);

    // Shared scan unit: one task's age against the stall window per cycle.
    assign age        = time_reg - beat_time[idx_reg];
    assign task_stale = !seen_reg[idx_reg] || (age > stall_window_reg);

    assign grace_now = (time_reg < grace_period_reg);
    assign dog_dec   = (dog_reg != '0) ? dog_reg - 1'b1 : dog_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == hbw_pkg::ACT_TICK && check_due)
                        state_next = hbw_pkg::ST_GRACE;
                    else
                        state_next = hbw_pkg::ST_DONE;
                end
            end
            hbw_pkg::ST_GRACE:
            begin
                if (grace_now)
                    state_next = hbw_pkg::ST_DONE;
                else
                    state_next = hbw_pkg::ST_SCAN;
            end
            hbw_pkg::ST_SCAN:
            begin
                if (idx_reg == LastIdx)
                    state_next = hbw_pkg::ST_DONE;
            end
            hbw_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = hbw_pkg::ST_IDLE;
            end
            default: state_next = hbw_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        time_next      = time_reg;
        ccount_next    = ccount_reg;
        dog_next       = dog_reg;
        tripped_next   = tripped_reg;
        seen_next      = seen_reg;
        tick_next      = tick_reg;
        fed_next       = fed_reg;
        stall_next     = stall_reg;
        alive_next     = alive_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            hbw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    fed_next   = 1'b0;
                    stall_next = 1'b0;
                    alive_next = 1'b1;
                    idx_next   = '0;
                    if (s_tuser == hbw_pkg::ACT_TICK)
                    begin
                        tick_next   = 1'b1;
                        time_next   = time_reg + 1'b1;
                        ccount_next = check_due ? '0 : ccount_inc;
                    end
                    else
                    begin
                        tick_next = 1'b0;
                        if (beat_ok)
                            seen_next[s_tdata[IdxW-1:0]] = 1'b1;
                    end
                end
            end
            hbw_pkg::ST_GRACE:
            begin
                if (grace_now)
                    fed_next = 1'b1;
            end
            hbw_pkg::ST_SCAN:
            begin
                if (task_stale)
                    alive_next = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LastIdx)
                begin
                    fed_next   = alive_reg && !task_stale;
                    stall_next = !(alive_reg && !task_stale);
                end
            end
            hbw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    if (tick_reg)
                    begin
                        if (fed_reg)
                            dog_next = dog_reload_reg;
                        else
                        begin
                            dog_next = dog_dec;
                            if (dog_dec == '0)
                                tripped_next = 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {dog_next, tripped_next, grace_now,
                                      stall_reg, fed_reg};
                end
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_period_reg <= hbw_pkg::CHECK_PERIOD_RST;
            stall_window_reg <= hbw_pkg::STALL_WINDOW_RST;
            grace_period_reg <= hbw_pkg::GRACE_PERIOD_RST;
            dog_reload_reg   <= hbw_pkg::DOG_RELOAD_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                hbw_pkg::REG_CHECK_PERIOD: check_period_reg <= wr_data[hbw_pkg::PeriodW-1:0];
                hbw_pkg::REG_STALL_WINDOW: stall_window_reg <= wr_data;
                hbw_pkg::REG_GRACE_PERIOD: grace_period_reg <= wr_data;
                hbw_pkg::REG_DOG_RELOAD:   dog_reload_reg   <= wr_data[hbw_pkg::DogW-1:0];
                default: ;
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbw_pkg::ST_IDLE;
            time_reg      <= '0;
            ccount_reg    <= '0;
            dog_reg       <= hbw_pkg::DOG_RELOAD_RST;
            tripped_reg   <= 1'b0;
            seen_reg      <= '0;
            tick_reg      <= 1'b0;
            fed_reg       <= 1'b0;
            stall_reg     <= 1'b0;
            alive_reg     <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            ccount_reg    <= ccount_next;
            dog_reg       <= dog_next;
            tripped_reg   <= tripped_next;
            seen_reg      <= seen_next;
            tick_reg      <= tick_next;
            fed_reg       <= fed_next;
            stall_reg     <= stall_next;
            alive_reg     <= alive_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // heartbeat timestamps; an entry only counts once its seen bit is set
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == hbw_pkg::ACT_BEAT && beat_ok)
            beat_time[s_tdata[IdxW-1:0]] <= time_reg;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[bench/hbw_tb_pkg.sv]
// Status predictor and scoreboard for the task heartbeat watchdog bench.
package hbw_tb_pkg;

    import hbw_pkg::*;

    // One result word, fed in bit 0.
    typedef struct packed {
        logic [DogW-1:0] dog_count;
        logic            expired;
        logic            in_grace;
        logic            stall_found;
        logic            fed;
    } wd_status_t;

    class watchdog_scoreboard;
        int unsigned n_tasks;

        // register shadows
        logic [PeriodW-1:0] check_period;
        logic [TimeW-1:0]   stall_window;
        logic [TimeW-1:0]   grace_period;
        logic [DogW-1:0]    dog_reload;

        // predicted block state
        logic [TimeW-1:0]   now_ticks;
        logic [TimeW-1:0]   beat_stamp [16];
        bit                 beat_seen  [16];
        logic [PeriodW-1:0] ticks_since_check;
        logic [DogW-1:0]    countdown;
        bit                 tripped;

        wd_status_t expected_status [$];

        int unsigned errors;
        int unsigned checked;
        int unsigned feeds;
        int unsigned stalls;

        function new(int unsigned tasks);
            int i;
            n_tasks           = tasks;
            check_period      = CHECK_PERIOD_RST;
            stall_window      = STALL_WINDOW_RST;
            grace_period      = GRACE_PERIOD_RST;
            dog_reload        = DOG_RELOAD_RST;
            now_ticks         = '0;
            ticks_since_check = '0;
            countdown         = DOG_RELOAD_RST;
            tripped           = 1'b0;
            errors            = 0;
            checked           = 0;
            feeds             = 0;
            stalls            = 0;
            for (i = 0; i < 16; i++)
            begin
                beat_stamp[i] = '0;
                beat_seen[i]  = 1'b0;
            end
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
            case (idx)
                REG_CHECK_PERIOD: check_period = value[PeriodW-1:0];
                REG_STALL_WINDOW: stall_window = value[TimeW-1:0];
                REG_GRACE_PERIOD: grace_period = value[TimeW-1:0];
                REG_DOG_RELOAD:   dog_reload   = value[DogW-1:0];
                default:          ;
            endcase
        endfunction

        // every task has reported, and none longer ago than the window (mod 2^32)
        function bit every_task_alive();
            int i;
            logic [TimeW-1:0] age;
            for (i = 0; i < n_tasks; i++)
            begin
                if (!beat_seen[i])
                    return 1'b0;
                age = now_ticks - beat_stamp[i];
                if (age > stall_window)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function wd_status_t predict_status(logic action, logic [TaskW-1:0] task_no);
            wd_status_t s;
            bit feed;
            bit stall;
            s     = '0;
            feed  = 1'b0;
            stall = 1'b0;
            if (action == ACT_BEAT)
            begin
                if (task_no < n_tasks)
                begin
                    beat_stamp[task_no] = now_ticks;
                    beat_seen[task_no]  = 1'b1;
                end
            end
            else
            begin
                now_ticks         = now_ticks + 1'b1;
                ticks_since_check = ticks_since_check + 1'b1;
                // a zero period compares true on every tick
                if (ticks_since_check >= check_period)
                begin
                    ticks_since_check = '0;
                    if (now_ticks < grace_period)
                        feed = 1'b1;
                    else if (every_task_alive())
                        feed = 1'b1;
                    else
                        stall = 1'b1;
                end
                if (feed)
                    countdown = dog_reload;
                else
                begin
                    if (countdown != 0)
                        countdown = countdown - 1'b1;
                    if (countdown == 0)
                        tripped = 1'b1;
                end
            end
            s.fed         = feed;
            s.stall_found = stall;
            s.in_grace    = (now_ticks < grace_period);
            s.expired     = tripped;
            s.dog_count   = countdown;
            return s;
        endfunction

        function void note_word(logic action, logic [TaskW-1:0] task_no);
            expected_status.push_back(predict_status(action, task_no));
        endfunction

        function void check_word(logic [15:0] data);
            wd_status_t got;
            wd_status_t want;
            got = data;
            if (expected_status.size() == 0)
            begin
                $error("result word %h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            checked++;
            if (want.fed)
                feeds++;
            if (want.stall_found)
                stalls++;
            if (got.fed !== want.fed)
            begin
                $error("fed: expected %0d, got %0d", want.fed, got.fed);
                errors++;
            end
            if (got.stall_found !== want.stall_found)
            begin
                $error("stall_found: expected %0d, got %0d", want.stall_found, got.stall_found);
                errors++;
            end
            if (got.in_grace !== want.in_grace)
            begin
                $error("in_grace: expected %0d, got %0d", want.in_grace, got.in_grace);
                errors++;
            end
            if (got.expired !== want.expired)
            begin
                $error("expired: expected %0d, got %0d", want.expired, got.expired);
                errors++;
            end
            if (got.dog_count !== want.dog_count)
            begin
                $error("dog_count: expected %0d, got %0d", want.dog_count, got.dog_count);
                errors++;
            end
        endfunction
    endclass

endpackage

[bench/task_heartbeat_watchdog_tb.sv]
// Top-level bench: drives tick and heartbeat words, checks every status word.
module task_heartbeat_watchdog_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hbw_pkg::*;
    import hbw_tb_pkg::*;

    localparam int          TASKS       = 8;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 122;
    // the slowest word is a check after grace, which scans every task;
    // for roughly 1000 words this limit is ample
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        wr_en    = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [31:0] wr_data  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [3:0] task_number, [7:4] zero
    logic        s_tuser  = 1'b0; // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] fed, [1] stall_found, [2] in_grace,
                                  // [3] expired, [15:4] dog_count

    watchdog_scoreboard status_board;

    int unsigned cycles       = 0;
    int unsigned words_sent   = 0;
    int unsigned ticks_sent   = 0;
    int unsigned useful_words = 0;   // ignored heartbeats not counted
    int unsigned settings     = 0;
    bit          calm_in      = 1'b0; // no gaps on the input side this phase
    bit          calm_out     = 1'b0; // no stalls on the result side this phase

    always #2 clk = ~clk;

    task_heartbeat_watchdog #(
        .TASKS(TASKS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Run guard: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("task_heartbeat_watchdog regression: fail");
            $finish;
        end
    end

    // Result side: random stall before each word, then take it and check it.
    // tready stays high across back-to-back words so it never gets two
    // assignments in one step.
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            status_board.check_word(m_tdata);
        end
    end

    // One word on the input side. valid is left high after the handshake;
    // the next call either keeps it (no gap) or drops it for the gap.
    task automatic send_word(input logic act, input logic [TaskW-1:0] tsk);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, tsk};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        status_board.note_word(act, tsk);
        words_sent++;
        if (act == ACT_TICK)
            ticks_sent++;
        if (act == ACT_TICK || tsk < TASKS)
            useful_words++;
    endtask

    task automatic run_ticks(input int unsigned n);
        repeat (n) send_word(ACT_TICK, '0);
    endtask

    // Heartbeats from every task in shuffled order, optionally one left out
    // so the following check sees a stale or silent task.
    task automatic beat_round(input bit drop_one);
        int order [TASKS];
        int i;
        int j;
        int tmp;
        int skip;
        for (i = 0; i < TASKS; i++)
            order[i] = i;
        for (i = TASKS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skip = drop_one ? $urandom_range(0, TASKS - 1) : -1;
        for (i = 0; i < TASKS; i++)
            if (i != skip)
                send_word(ACT_BEAT, TaskW'(order[i]));
    endtask

    // Drop valid, let every outstanding result drain, then a short settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_board.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        status_board.set_reg(idx, value);
    endtask

    // Full register setting, applied only with the block idle.
    task automatic configure(input logic [CfgW-1:0] period, input logic [CfgW-1:0] window,
                             input logic [CfgW-1:0] grace, input logic [CfgW-1:0] reload);
        drain();
        write_reg(REG_CHECK_PERIOD, period);
        write_reg(REG_STALL_WINDOW, window);
        write_reg(REG_GRACE_PERIOD, grace);
        write_reg(REG_DOG_RELOAD, reload);
        wr_en <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    initial
    begin : stimulus
        int          phase;
        int unsigned target;
        int unsigned window_hint;
        int unsigned n;
        int          i;
        logic [31:0] junk;
        logic [15:0] period;
        logic [31:0] window;
        logic [31:0] grace;
        logic [11:0] reload;

        status_board = new(TASKS);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // Reset values: heartbeats at both ends of the task field, two
        // out-of-range tasks that must be ignored, ticks inside grace.
        send_word(ACT_BEAT, 4'd0);
        send_word(ACT_BEAT, 4'd15);
        send_word(ACT_BEAT, 4'd8);
        send_word(ACT_BEAT, 4'd7);
        run_ticks(3);

        // Check every tick, endless grace, largest reload: grace feed.
        configure(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4095);
        run_ticks(2);

        // Longest period, grace over: ticks with no check.
        configure(32'd65535, 32'd1, 32'd0, 32'd0);
        run_ticks(1);

        // Zero period acts as a check each tick. First a silent-task stall,
        // then a fresh round feeds with zero reload, then the next tick goes
        // stale and the counter trips at zero.
        configure(32'd0, 32'd1, 32'd0, 32'd0);
        run_ticks(1);
        for (i = 0; i < TASKS; i++)
            send_word(ACT_BEAT, TaskW'(i));
        run_ticks(2);

        // --- random part ---
        // Mostly full heartbeat rounds followed by a burst of ticks sized
        // around the stall window, so post-grace checks both pass and fail;
        // the rest is noise with random actions and any task number.
        for (phase = 0; phase < PHASES; phase++)
        begin
            junk = $urandom;
            case ($urandom_range(0, 9))
                0:       period = 16'd0;
                1:       period = 16'd65535;
                default: period = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       window = 32'hFFFF_FFFF;
                1:       window = 32'd0;
                default: window = $urandom_range(0, 24);
            endcase
            case ($urandom_range(0, 9))
                0:       grace = 32'd0;
                1:       grace = 32'hFFFF_FFFF;
                default: grace = status_board.now_ticks + $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 9))
                0:       reload = 12'd0;
                1:       reload = 12'd4095;
                default: reload = 12'($urandom_range(1, 60));
            endcase
            window_hint = (window > 24) ? 24 : window;

            // unused upper data bits carry junk on the narrow registers
            configure({junk[31:16], period}, window, grace, {junk[19:0], reload});
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);

            target = useful_words + PHASE_WORDS;
            while (useful_words < target)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    beat_round($urandom_range(0, 4) == 0);
                    run_ticks($urandom_range(1, window_hint + 4));
                end
                else
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_word(1'($urandom_range(0, 1)), TaskW'($urandom_range(0, 15)));
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);

        if (status_board.expected_status.size() != 0)
        begin
            $error("%0d expected result words never arrived",
                   status_board.expected_status.size());
            status_board.errors++;
        end

        $display("covered %0d words (%0d ticks) over %0d register settings",
                 words_sent, ticks_sent, settings);
        $display("checked %0d status words: %0d feeds, %0d stall checks, %0d mismatches",
                 status_board.checked, status_board.feeds, status_board.stalls,
                 status_board.errors);
        if (status_board.errors == 0)
            $display("task_heartbeat_watchdog regression: pass");
        else
            $display("task_heartbeat_watchdog regression: fail");
        $finish;
    end

endmodule
